// File: hdl/lip_pkg.sv
package lip_pkg;

   localparam int SAMPLE_W      = 32;
   localparam int COEF_W        = 16;
   localparam int COEF_SLOTS    = 4;
   localparam int CFG_W         = COEF_W * COEF_SLOTS;
   localparam int SHIFT_W       = 4;
   localparam int CSR_ADDR_W    = 2;
   localparam int PROD_W        = SAMPLE_W + COEF_W;
   localparam int TERM_W        = PROD_W + 1;
   localparam int DEFAULT_ORDER = 4;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_DIRECTION = 2'd0,
      CSR_SHIFT     = 2'd1,
      CSR_FF_COEFS  = 2'd2,
      CSR_FB_COEFS  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] a;
      logic signed [COEF_W-1:0] b;
   } tap_coef_type;

   function automatic logic signed [COEF_W-1:0] coef_at(input logic [CFG_W-1:0] word,
                                                        input int tap);
      logic signed [COEF_W-1:0] c;
      c = '0;
      if (tap < COEF_SLOTS) begin
         c = word[COEF_W*tap +: COEF_W];
      end
      return c;
   endfunction

endpackage

// File: hdl/lip_tap_cell.sv
module lip_tap_cell
   import lip_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic signed [SAMPLE_W-1:0] prev_plain,
   input  logic signed [SAMPLE_W-1:0] prev_coded,
   input  tap_coef_type               coefs,
   output logic signed [SAMPLE_W-1:0] plain_out,
   output logic signed [SAMPLE_W-1:0] coded_out,
   output logic signed [TERM_W-1:0]   term_out
);

   logic signed [SAMPLE_W-1:0] plain_ff, plain_in;
   logic signed [SAMPLE_W-1:0] coded_ff, coded_in;
   logic signed [TERM_W-1:0]   term_ff, term_in;
   logic signed [PROD_W-1:0]   prod_a, prod_b;

   always_comb begin
      plain_in = advance ? prev_plain : plain_ff;
      coded_in = advance ? prev_coded : coded_ff;
      prod_a   = coefs.a * plain_in;
      prod_b   = coefs.b * coded_in;
      term_in  = TERM_W'(prod_a) - TERM_W'(prod_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plain_ff <= '0;
         coded_ff <= '0;
         term_ff  <= '0;
      end else begin
         plain_ff <= plain_in;
         coded_ff <= coded_in;
         term_ff  <= term_in;
      end
   end

   assign plain_out = plain_ff;
   assign coded_out = coded_ff;
   assign term_out  = term_ff;

endmodule

// File: hdl/lip_quant.sv
module lip_quant
   import lip_pkg::*;
#(
   parameter int ACC_W = TERM_W + 3
)
(
   input  logic signed [ACC_W-1:0]    acc,
   input  logic        [SHIFT_W-1:0]  shift,
   input  logic                       direction,
   input  logic signed [SAMPLE_W-1:0] sample,
   output logic        [SAMPLE_W-1:0] result,
   output logic                       overflow
);

   logic signed [ACC_W-1:0] q;
   logic signed [ACC_W:0]   wide;

   always_comb begin
      q    = acc >>> shift;
      wide = direction ? (ACC_W+1)'(sample) - (ACC_W+1)'(q)
                       : (ACC_W+1)'(sample) + (ACC_W+1)'(q);
      overflow = !((&wide[ACC_W:SAMPLE_W-1]) || !(|wide[ACC_W:SAMPLE_W-1]));
      if (overflow) begin
         result = wide[ACC_W] ? SAMPLE_MIN : SAMPLE_MAX;
      end else begin
         result = wide[SAMPLE_W-1:0];
      end
   end

endmodule

// File: hdl/lossless_iir_predictor_core.sv
// A result beat is presented in the cycle after its sample beat is accepted.
// Throughput: one sample per cycle unless a csr write or a stalled result lowers req_tready;
// the bound is the tap-0 feedback multiply-add through quantise and saturate, all combinational.
// A csr write holds req_tready low for the following cycle while tap products refresh.
// Reset (synchronous, active high) clears both histories, the csr registers and rsp_tvalid.
module lossless_iir_predictor_core
   import lip_pkg::*;
#(
   parameter int ORDER = DEFAULT_ORDER
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [SAMPLE_W-1:0]   req_tdata,   // [31:0] sample_in
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [SAMPLE_W-1:0]   rsp_tdata,   // [31:0] sample_out
   output logic [0:0]            rsp_tuser,   // [0] overflow
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CFG_W-1:0]      csr_wdata
);

   localparam int ACC_W = TERM_W + $clog2(ORDER + 1);

   logic                       direction_ff;
   logic [SHIFT_W-1:0]         shift_ff;
   logic [CFG_W-1:0]           ff_coefs_ff;
   logic [CFG_W-1:0]           fb_coefs_ff;
   logic                       settle_ff;

   logic signed [SAMPLE_W-1:0] plain0_ff, plain0_in;
   logic signed [SAMPLE_W-1:0] coded0_ff, coded0_in;
   logic signed [TERM_W-1:0]   known_ff, known_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]        rsp_data_ff;
   logic                       rsp_ovf_ff;

   tap_coef_type               coefs [ORDER];
   logic signed [SAMPLE_W-1:0] plain_h [ORDER];
   logic signed [SAMPLE_W-1:0] coded_h [ORDER];
   logic signed [TERM_W-1:0]   term [ORDER];

   logic                       accept;
   logic signed [SAMPLE_W-1:0] sample;
   logic signed [SAMPLE_W-1:0] known_src;
   logic signed [COEF_W-1:0]   known_coef;
   logic signed [PROD_W-1:0]   known_prod;
   logic signed [PROD_W-1:0]   loop_prod;
   logic signed [TERM_W-1:0]   loop_term;
   logic signed [ACC_W-1:0]    acc;
   logic [SAMPLE_W-1:0]        result;
   logic                       overflow;

   assign accept     = req_tvalid && req_tready;
   assign sample     = req_tdata;
   assign req_tready = !settle_ff && (!rsp_valid_ff || rsp_tready);

   genvar j;
   generate
      for (j = 0; j < ORDER; j++) begin : g_coef
         assign coefs[j].a = coef_at(ff_coefs_ff, j);
         assign coefs[j].b = coef_at(fb_coefs_ff, j);
      end
      for (j = 1; j < ORDER; j++) begin : g_cell
         lip_tap_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .advance    (accept),
            .prev_plain (plain_h[j-1]),
            .prev_coded (coded_h[j-1]),
            .coefs      (coefs[j]),
            .plain_out  (plain_h[j]),
            .coded_out  (coded_h[j]),
            .term_out   (term[j])
         );
      end
   endgenerate

   assign plain_h[0] = plain0_ff;
   assign coded_h[0] = coded0_ff;
   assign term[0]    = known_ff;

   always_comb begin
      loop_prod = direction_ff ? coefs[0].a * plain0_ff : coefs[0].b * coded0_ff;
      loop_term = direction_ff ? TERM_W'(loop_prod) : -TERM_W'(loop_prod);
      acc = ACC_W'(loop_term);
      for (int k = 0; k < ORDER; k++) begin
         acc = acc + ACC_W'(term[k]);
      end
   end

   lip_quant #(
      .ACC_W (ACC_W)
   ) u_quant (
      .acc       (acc),
      .shift     (shift_ff),
      .direction (direction_ff),
      .sample    (sample),
      .result    (result),
      .overflow  (overflow)
   );

   always_comb begin
      plain0_in  = accept ? (direction_ff ? signed'(result) : sample) : plain0_ff;
      coded0_in  = accept ? (direction_ff ? sample : signed'(result)) : coded0_ff;
      known_src  = accept ? sample : (direction_ff ? coded0_ff : plain0_ff);
      known_coef = direction_ff ? coefs[0].b : coefs[0].a;
      known_prod = known_coef * known_src;
      known_in   = direction_ff ? -TERM_W'(known_prod) : TERM_W'(known_prod);
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= 1'b0;
         shift_ff     <= '0;
         ff_coefs_ff  <= '0;
         fb_coefs_ff  <= '0;
         settle_ff    <= 1'b0;
         plain0_ff    <= '0;
         coded0_ff    <= '0;
         known_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         settle_ff    <= csr_we;
         plain0_ff    <= plain0_in;
         coded0_ff    <= coded0_in;
         known_ff     <= known_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index_type'(csr_addr))
               CSR_DIRECTION: direction_ff <= csr_wdata[0];
               CSR_SHIFT:     shift_ff     <= csr_wdata[SHIFT_W-1:0];
               CSR_FF_COEFS:  ff_coefs_ff  <= csr_wdata;
               CSR_FB_COEFS:  fb_coefs_ff  <= csr_wdata;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
         rsp_ovf_ff  <= overflow;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_ovf_ff;

`ifndef SYNTHESIS
   a_settle_after_csr: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_tready)
      else $error("sample beat accepted straight after a csr write");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_tvalid)
      else $error("no result beat after an accepted sample");

   a_ovf_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == SAMPLE_MAX || rsp_tdata == SAMPLE_MIN)
      else $error("overflow flagged on an unsaturated sample");

   a_plain_enters: assert property (@(posedge clock) disable iff (reset)
      accept && !direction_ff |=> plain0_ff == $past(sample))
      else $error("encode sample missing from plain history");
`endif

endmodule

// File: tb/sv/tb_lossless_iir_predictor_core.sv
`timescale 1ns / 100ps

module tb_lossless_iir_predictor_core;
   import lip_pkg::*;

   localparam int ORDER = DEFAULT_ORDER;
   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_GAP = 50;
   localparam int HOLD_CYCLES = 150;
   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_out;
      logic                overflow;
   } coded_beat_type;

   class iir_tracker;
      logic                        direction;
      logic [SHIFT_W-1:0]          shift_amt;
      logic [CFG_W-1:0]            ff_coefs;
      logic [CFG_W-1:0]            fb_coefs;
      logic signed [SAMPLE_W-1:0]  plain_hist[ORDER];
      logic signed [SAMPLE_W-1:0]  coded_hist[ORDER];
      coded_beat_type              expected_beats[$];
      int                          errors;

      function new();
         direction = DIR_ENCODE;
         shift_amt = '0;
         ff_coefs  = '0;
         fb_coefs  = '0;
         errors    = 0;
         foreach (plain_hist[j]) begin
            plain_hist[j] = '0;
            coded_hist[j] = '0;
         end
      endfunction

      function void set_register(csr_index_type idx, logic [CFG_W-1:0] value);
         case (idx)
            CSR_DIRECTION: direction = value[0];
            CSR_SHIFT:     shift_amt = value[SHIFT_W-1:0];
            CSR_FF_COEFS:  ff_coefs  = value;
            CSR_FB_COEFS:  fb_coefs  = value;
            default: ;
         endcase
      endfunction

      function void note_sample(logic [SAMPLE_W-1:0] raw);
         logic signed [COEF_W-1:0]   a;
         logic signed [COEF_W-1:0]   b;
         logic signed [SAMPLE_W-1:0] s;
         logic signed [SAMPLE_W-1:0] res;
         longint                     acc;
         longint                     q;
         longint                     full;
         coded_beat_type             beat;
         s = raw;
         acc = 0;
         for (int j = 0; j < ORDER; j++) begin
            a = '0;
            b = '0;
            if (j < COEF_SLOTS) begin
               a = ff_coefs[COEF_W*j +: COEF_W];
               b = fb_coefs[COEF_W*j +: COEF_W];
            end
            acc += longint'(a) * longint'(plain_hist[j]);
            acc -= longint'(b) * longint'(coded_hist[j]);
         end
         q = acc >>> shift_amt;
         full = (direction == DIR_DECODE) ? longint'(s) - q : longint'(s) + q;
         beat.overflow = 1'b1;
         if (full > longint'($signed(SAMPLE_MAX)))
            res = SAMPLE_MAX;
         else if (full < longint'($signed(SAMPLE_MIN)))
            res = SAMPLE_MIN;
         else begin
            res = full[SAMPLE_W-1:0];
            beat.overflow = 1'b0;
         end
         beat.sample_out = res;
         for (int j = ORDER - 1; j > 0; j--) begin
            plain_hist[j] = plain_hist[j-1];
            coded_hist[j] = coded_hist[j-1];
         end
         plain_hist[0] = (direction == DIR_DECODE) ? res : s;
         coded_hist[0] = (direction == DIR_DECODE) ? s : res;
         expected_beats.push_back(beat);
      endfunction

      function void check_result(logic [SAMPLE_W-1:0] sample_out, logic overflow);
         coded_beat_type want;
         if (expected_beats.size() == 0) begin
            $error("unexpected result beat: sample_out %h overflow %b", sample_out, overflow);
            errors++;
            return;
         end
         want = expected_beats.pop_front();
         if (sample_out !== want.sample_out) begin
            $error("sample_out: expected %h, got %h", want.sample_out, sample_out);
            errors++;
         end
         if (overflow !== want.overflow) begin
            $error("overflow: expected %b, got %b", want.overflow, overflow);
            errors++;
         end
      endfunction

      function int pending();
         return expected_beats.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [SAMPLE_W-1:0]   req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [SAMPLE_W-1:0]   rsp_tdata;
   logic [0:0]            rsp_tuser;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CFG_W-1:0]      csr_wdata = '0;

   iir_tracker tracker;
   int         tx_idle_pct = 0;
   int         rx_stall_pct = 0;
   int         hold_req = 0;
   int         hold_seen = 0;
   int         hold_left = 0;
   int         cycle_count = 0;

   lossless_iir_predictor_core #(.ORDER(ORDER)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // hold off the result side while a long stall is pending
   always @(negedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen  <= hold_req;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_result(rsp_tdata, rsp_tuser[0]);
   end

   task automatic write_csr(csr_index_type idx, logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      tracker.set_register(idx, value);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic configure(logic dir, logic [SHIFT_W-1:0] shift,
                            logic [CFG_W-1:0] ff, logic [CFG_W-1:0] fb);
      write_csr(CSR_DIRECTION, CFG_W'(dir));
      write_csr(CSR_SHIFT, CFG_W'(shift));
      write_csr(CSR_FF_COEFS, ff);
      write_csr(CSR_FB_COEFS, fb);
   endtask

   // entered and left at a falling edge
   task automatic send_sample(logic [SAMPLE_W-1:0] value);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct)
         gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do
         @(posedge clock);
      while (!req_tready);
      tracker.note_sample(value);
      @(negedge clock);
   endtask

   task automatic run_phase(logic [SAMPLE_W-1:0] samples[$], int tx_pct, int rx_pct,
                            bit pressure);
      tx_idle_pct  = tx_pct;
      rx_stall_pct = rx_pct;
      @(posedge clock);
      if (pressure)
         hold_req++;
      @(negedge clock);
      foreach (samples[i])
         send_sample(samples[i]);
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] random_sample();
      logic [SAMPLE_W-1:0] v;
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(4))
               0: v = SAMPLE_MAX;
               1: v = SAMPLE_MIN;
               2: v = '0;
               3: v = '1;
               default: v = 32'd1;
            endcase
         end
         1, 2: v = $urandom;
         default: v = $signed($urandom) >>> $urandom_range(8, 30);
      endcase
      return v;
   endfunction

   function automatic logic [CFG_W-1:0] random_coefs();
      logic [CFG_W-1:0]         w;
      logic signed [COEF_W-1:0] c;
      w = '0;
      for (int t = 0; t < COEF_SLOTS; t++) begin
         case ($urandom_range(3))
            0: c = COEF_W'($urandom);
            1, 2: c = $signed(COEF_W'($urandom)) >>> $urandom_range(3, 14);
            default: c = '0;
         endcase
         w[COEF_W*t +: COEF_W] = c;
      end
      return w;
   endfunction

   initial begin
      logic [SAMPLE_W-1:0] batch[$];
      logic [SHIFT_W-1:0]  shift;
      int                  tx_pct;
      int                  rx_pct;

      tracker = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // registers at their reset values: output follows input
      batch = '{SAMPLE_MAX, SAMPLE_MIN, 32'd0, '1, 32'd1};
      run_phase(batch, 0, 0, 1'b0);

      // extreme coefficients drive saturation both ways
      configure(DIR_ENCODE, 4'd0, {COEF_SLOTS{16'h7FFF}}, {COEF_SLOTS{16'h8000}});
      batch = '{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, 32'd12345};
      run_phase(batch, 0, 0, 1'b0);

      // decode with the shift above fourteen
      configure(DIR_DECODE, 4'd15, {COEF_SLOTS{16'h8000}}, {COEF_SLOTS{16'h7FFF}});
      batch = '{SAMPLE_MIN, SAMPLE_MAX, '1, 32'd0, 32'd1, 32'h5555_5555};
      run_phase(batch, 0, 0, 1'b0);

      configure(DIR_DECODE, 4'd14, {COEF_SLOTS{16'hFFFF}}, '0);
      batch = '{SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 32'h2AAA_AAAA};
      run_phase(batch, 0, 0, 1'b0);

      for (int p = 0; p < 10; p++) begin
         case (p)
            0: shift = 4'd0;
            1: shift = 4'd15;
            default: shift = SHIFT_W'($urandom_range(15));
         endcase
         configure(logic'($urandom_range(1)), shift, random_coefs(), random_coefs());
         case (p % 4)
            0: begin tx_pct = 0;  rx_pct = 0;  end
            1: begin tx_pct = 82; rx_pct = 0;  end
            2: begin tx_pct = 0;  rx_pct = 82; end
            default: begin tx_pct = 10; rx_pct = 10; end
         endcase
         batch.delete();
         repeat (55) batch.push_back(random_sample());
         run_phase(batch, tx_pct, rx_pct, p == 4);
      end

      if (tracker.errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// File: lossless_iir_predictor_core.f
hdl/lip_pkg.sv
hdl/lip_tap_cell.sv
hdl/lip_quant.sv
hdl/lossless_iir_predictor_core.sv
tb/sv/tb_lossless_iir_predictor_core.sv
